// ----- hw/rtl/okvt_pkg.sv -----
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types and constants for the ordered key/value table: table depth,
// derived widths, operation and status codes, word types and the command
// that is broadcast to every cell of the table.
// ----------------------------------------------------------------------------
package okvt_pkg;

	localparam int TABLE_DEPTH = 128;
	// Width of a count that can hold TABLE_DEPTH itself.
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	// Width of a cell position.
	localparam int POS_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int IDX_W = 7;
	localparam int OCNT_W = 8;
	// Common width for comparing a cell position with a requested index.
	localparam int IDX_CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_MISS  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		op_t              req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
	} req_word_t;

	typedef struct packed {
		status_t           status;
		logic [KEY_W-1:0]  found_key;
		logic [VAL_W-1:0]  found_value;
		logic [OCNT_W-1:0] entry_count;
	} rsp_word_t;

	// Command seen by every cell in the same cycle.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
		logic             is_read;
		logic             wr_add;
		logic             wr_shift;
	} cell_cmd_t;

endpackage

// ----- hw/rtl/ordered_key_value_table.sv -----
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Insertion-ordered key/value table built as a row of cells.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH entries in the order they were added,
// one entry per cell. Every request word gives exactly one response word.
// A request runs in a compare step and a final step: first, every cell
// compares its key with the request key and registers the result; then the
// first-match flag runs up the row of cells, the selected entry is gathered,
// the table is updated (append on add, shift down by one on delete) and the
// response is loaded into the output register. A new request is taken in the
// same cycle that the previous one completes, never while one is still in its
// compare step. The final step waits while an earlier response has not been
// taken. Add appends without checking for duplicate keys and is refused with
// status full when the table is full. Search and delete act on the
// lowest-position matching entry. Read returns the entry at the given
// position, or status range when that position holds no entry. The entry
// count reported is the count after the request, masked to eight bits.
// There is no clearing pass: reset zeroes the entry count, not the cells.
// ----------------------------------------------------------------------------
module ordered_key_value_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  okvt_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output okvt_pkg::rsp_word_t rsp
);
	import okvt_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_MATCH = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t           state_q;
	req_word_t        req_q;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	cell_cmd_t        cmd;
	logic             exec_fire;
	logic             req_fire;
	logic             full;
	logic             any_hit;
	logic             read_hit;
	logic [CNT_W-1:0] count_next;
	status_t          status_next;
	logic [KEY_W-1:0] gather_key;
	logic [VAL_W-1:0] gather_value;

	logic [KEY_W-1:0] cell_key   [TABLE_DEPTH];
	logic [VAL_W-1:0] cell_value [TABLE_DEPTH];
	logic [KEY_W-1:0] up_key     [TABLE_DEPTH];
	logic [VAL_W-1:0] up_value   [TABLE_DEPTH];
	logic [TABLE_DEPTH:0]   hit_chain;
	logic [TABLE_DEPTH-1:0] cell_sel;

	// The final cycle completes only when the output register is free.
	assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == S_IDLE) || exec_fire;
	assign req_fire  = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) state_q <= S_MATCH;
				end
				S_MATCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_fire) state_q <= req_fire ? S_MATCH : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
	end

	// Decisions of the final cycle.
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign any_hit  = hit_chain[TABLE_DEPTH];
	assign read_hit = |cell_sel;

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		case (req_q.req_type)
			OP_ADD: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				if (!any_hit) status_next = ST_MISS;
			end
			OP_DELETE: begin
				if (any_hit) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status_next = ST_MISS;
				end
			end
			OP_READ: begin
				if (!read_hit) status_next = ST_RANGE;
			end
			default: begin
				status_next = ST_DONE;
			end
		endcase
	end

	// Command broadcast to the row. The table only changes when the request
	// completes, so the match bits registered in the compare cycle stay valid
	// while the final cycle waits.
	always_comb begin
		cmd.key      = req_q.key;
		cmd.value    = req_q.value;
		cmd.index    = req_q.index;
		cmd.count    = count_q;
		cmd.is_read  = (req_q.req_type == OP_READ);
		cmd.wr_add   = exec_fire && (req_q.req_type == OP_ADD) && !full;
		cmd.wr_shift = exec_fire && (req_q.req_type == OP_DELETE) && any_hit;
	end

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_top
			// The top cell takes don't-care data on a shift; the count drops.
			assign up_key[i]   = '0;
			assign up_value[i] = '0;
		end else begin : g_mid
			assign up_key[i]   = cell_key[i+1];
			assign up_value[i] = cell_value[i+1];
		end

		okvt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.pos        (POS_W'(i)),
			.next_key   (up_key[i]),
			.next_value (up_value[i]),
			.hit_in     (hit_chain[i]),
			.hit_out    (hit_chain[i+1]),
			.sel        (cell_sel[i]),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i])
		);
	end

	// At most one cell is selected, so an OR of the masked entries gathers it.
	always_comb begin
		gather_key   = '0;
		gather_value = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			gather_key   = gather_key | (cell_key[i] & {KEY_W{cell_sel[i]}});
			gather_value = gather_value | (cell_value[i] & {VAL_W{cell_sel[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q.status      <= status_next;
			rsp_q.entry_count <= OCNT_W'(count_next);
			if (req_q.req_type == OP_ADD) begin
				rsp_q.found_key   <= '0;
				rsp_q.found_value <= '0;
			end else begin
				rsp_q.found_key   <= gather_key;
				rsp_q.found_value <= gather_value;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/okvt_cell.sv -----
// ----------------------------------------------------------------------------
// okvt_cell
// One entry of the table. Holds a key/value pair, compares its key with the
// request, passes a first-match flag up the chain and takes its upper
// neighbor's entry when a delete closes the gap.
// ----------------------------------------------------------------------------
module okvt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  okvt_pkg::cell_cmd_t        cmd,
	input  logic [okvt_pkg::POS_W-1:0] pos,
	input  logic [okvt_pkg::KEY_W-1:0] next_key,
	input  logic [okvt_pkg::VAL_W-1:0] next_value,
	input  logic                       hit_in,
	output logic                       hit_out,
	output logic                       sel,
	output logic [okvt_pkg::KEY_W-1:0] key_q,
	output logic [okvt_pkg::VAL_W-1:0] value_q
);
	import okvt_pkg::*;

	logic held;
	logic match_d;
	logic match_q;
	logic rd_sel;

	assign held    = CNT_W'(pos) < cmd.count;
	assign match_d = held && (key_q == cmd.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= match_d;
		end
	end

	// The flag is set at the first matching cell and stays set above it.
	assign hit_out = hit_in | match_q;
	assign rd_sel  = held && (IDX_CMP_W'(pos) == IDX_CMP_W'(cmd.index));
	assign sel     = cmd.is_read ? rd_sel : (match_q & ~hit_in);

	always_ff @(posedge clk) begin
		if (cmd.wr_add && (CNT_W'(pos) == cmd.count)) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
		end else if (cmd.wr_shift && hit_out) begin
			key_q   <= next_key;
			value_q <= next_value;
		end
	end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered key/value table. A shadow copy of the
// table predicts every response word. Random request words drive the table
// through fill and drain cycles, and the run walks through several
// handshake idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import okvt_pkg::*;

	// The slowest legal run finishes far below this. Hitting it means the
	// table hung.
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 360;
	localparam int MAX_REPORTS = 10;
	// The read index can only address the first 2**IDX_W positions.
	localparam int IDX_SPAN = 1 << IDX_W;

	// Shadow copy of the table. Each accepted request word is applied here
	// at once, and the response word that it must cause is queued in order.
	class kv_table_shadow;
		bit [KEY_W-1:0] keys [TABLE_DEPTH];
		bit [VAL_W-1:0] vals [TABLE_DEPTH];
		int held;
		rsp_word_t pending [$];
		int responses_seen;
		int failures;

		function void apply_request(req_word_t r);
			rsp_word_t e;
			int pos;
			e.status = ST_DONE;
			e.found_key = '0;
			e.found_value = '0;
			case (r.req_type)
				OP_ADD: begin
					if (held < TABLE_DEPTH) begin
						keys[held] = r.key;
						vals[held] = r.value;
						held++;
					end else begin
						e.status = ST_FULL;
					end
				end
				OP_SEARCH, OP_DELETE: begin
					pos = held;
					for (int i = held - 1; i >= 0; i--)
						if (keys[i] == r.key)
							pos = i;
					if (pos == held) begin
						e.status = ST_MISS;
					end else begin
						e.found_key = keys[pos];
						e.found_value = vals[pos];
						if (r.req_type == OP_DELETE) begin
							for (int i = pos; i < held - 1; i++) begin
								keys[i] = keys[i + 1];
								vals[i] = vals[i + 1];
							end
							held--;
						end
					end
				end
				default: begin
					if (int'(r.index) < held) begin
						e.found_key = keys[r.index];
						e.found_value = vals[r.index];
					end else begin
						e.status = ST_RANGE;
					end
				end
			endcase
			e.entry_count = OCNT_W'(held);
			pending.push_back(e);
		endfunction

		function void check_response(rsp_word_t a);
			rsp_word_t e;
			responses_seen++;
			if (pending.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("%0t: response word %0d with nothing outstanding: status=%0d key=%h value=%h count=%0d",
						$realtime, responses_seen, a.status, a.found_key, a.found_value,
						a.entry_count);
				failures++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status || a.found_key !== e.found_key ||
					a.found_value !== e.found_value || a.entry_count !== e.entry_count) begin
				if (failures < MAX_REPORTS) begin
					$display("%0t: mismatch on response word %0d", $realtime, responses_seen);
					$display("  expected status=%0d key=%h value=%h count=%0d",
						e.status, e.found_key, e.found_value, e.entry_count);
					$display("  actual   status=%0d key=%h value=%h count=%0d",
						a.status, a.found_key, a.found_value, a.entry_count);
				end
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp;

	// Percent chance, per cycle, that the sender holds back a word or the
	// receiver refuses one. The phases of the run change these.
	int send_idle_pct = 0;
	int stall_pct = 0;

	kv_table_shadow table_shadow = new();
	// A few keys reused on purpose so that duplicates pile up in the table.
	bit [KEY_W-1:0] key_pool [8];

	ordered_key_value_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Response side. The word is checked from the values that were present
	// just before the edge, then ready is redrawn for the next cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			table_shadow.check_response(rsp);
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: a hung table ends the run here.
	int unsigned cycle_count = 0;
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic bit [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic req_word_t make_req(op_t op, bit [KEY_W-1:0] k, bit [VAL_W-1:0] v,
			bit [IDX_W-1:0] idx);
		req_word_t r;
		r.req_type = op;
		r.key = k;
		r.value = v;
		r.index = idx;
		return r;
	endfunction

	// Draws the next random request word. While filling, adds dominate so the
	// table reaches full and refused adds happen. While draining, deletes
	// dominate so the table empties again. Search and delete keys mostly come
	// from entries actually held, so hits are common, while reads mostly
	// land below the entry count. Fields that an operation ignores still
	// carry random content.
	function automatic req_word_t pick_request(bit filling);
		req_word_t r;
		int roll;
		int held;
		int reach;
		held = table_shadow.held;
		reach = (held < IDX_SPAN) ? held : IDX_SPAN;
		roll = $urandom_range(0, 99);
		r.key = rand_word();
		r.value = rand_word();
		r.index = IDX_W'($urandom_range(0, IDX_SPAN - 1));
		if (filling)
			r.req_type = (roll < 70) ? OP_ADD : (roll < 80) ? OP_SEARCH :
				(roll < 88) ? OP_DELETE : OP_READ;
		else
			r.req_type = (roll < 10) ? OP_ADD : (roll < 25) ? OP_SEARCH :
				(roll < 80) ? OP_DELETE : OP_READ;
		roll = $urandom_range(0, 99);
		case (r.req_type)
			OP_ADD: begin
				if (roll < 30)
					r.key = key_pool[$urandom_range(0, 7)];
			end
			OP_SEARCH, OP_DELETE: begin
				if (roll < 75 && held > 0)
					r.key = table_shadow.keys[$urandom_range(0, held - 1)];
				else if (roll < 90)
					r.key = key_pool[$urandom_range(0, 7)];
			end
			default: begin
				if (roll < 80 && reach > 0)
					r.index = IDX_W'($urandom_range(0, reach - 1));
			end
		endcase
		return r;
	endfunction

	// Offers one request word and returns at the edge where it is taken. The
	// valid line is only lowered when a gap is actually inserted, so a word
	// that follows directly never sees valid drop and rise in the same step.
	task automatic send_request(input req_word_t w);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		table_shadow.apply_request(w);
	endtask

	// Holds the sender off until every outstanding response word is back.
	// At least one edge passes, so valid is never written twice in a step.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (table_shadow.pending.size() != 0);
	endtask

	initial begin
		bit [KEY_W-1:0] k1;
		bit filling;
		int linger;
		k1 = 64'h0123_4567_89AB_CDEF;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = rand_word();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. An empty table answers every lookup with a miss
		// or a range error.
		send_request(make_req(OP_READ, '1, '1, '0));
		send_request(make_req(OP_SEARCH, '0, '0, '1));
		send_request(make_req(OP_DELETE, '1, '0, '0));
		// Extreme keys and values, then the same key twice so the first
		// match rule is exercised.
		send_request(make_req(OP_ADD, '0, '1, '1));
		send_request(make_req(OP_ADD, '1, '0, '0));
		send_request(make_req(OP_ADD, k1, 64'hAAAA_AAAA_AAAA_AAAA, '0));
		send_request(make_req(OP_ADD, k1, 64'h5555_5555_5555_5555, '1));
		send_request(make_req(OP_SEARCH, k1, '1, '0));
		send_request(make_req(OP_SEARCH, '0, '0, '0));
		send_request(make_req(OP_READ, '0, '0, 7'd1));
		// Reads at the count and at the largest index both fall out of range.
		send_request(make_req(OP_READ, '0, '0, '1));
		send_request(make_req(OP_READ, '1, '1, 7'd4));
		// Deleting the first of two duplicates exposes the second one.
		send_request(make_req(OP_DELETE, k1, '0, '0));
		send_request(make_req(OP_SEARCH, k1, '0, '0));
		send_request(make_req(OP_READ, '0, '0, 7'd2));
		// Repeated deletes at the front, each shifting the rest down.
		send_request(make_req(OP_DELETE, '0, '1, '1));
		send_request(make_req(OP_READ, '0, '0, '0));
		send_request(make_req(OP_DELETE, '1, '0, '0));
		send_request(make_req(OP_SEARCH, 64'h5555_5555_5555_5555, '0, '0));
		send_request(make_req(OP_DELETE, k1, '0, '0));
		send_request(make_req(OP_READ, '0, '0, '0));
		wait_for_drain();

		// Random part in four idling phases: none, sender idle, receiver
		// stalling, both. Fill and drain cycles carry over across phases.
		// Once full, a few more words go in while filling so that refused
		// adds are seen.
		filling = 1'b1;
		linger = $urandom_range(2, 6);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 81;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 81;
				end
				default: begin
					send_idle_pct = 32;
					stall_pct = 32;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (filling && table_shadow.held >= TABLE_DEPTH) begin
					if (linger == 0)
						filling = 1'b0;
					else
						linger--;
				end else if (!filling && table_shadow.held == 0) begin
					filling = 1'b1;
					linger = $urandom_range(2, 6);
				end
				send_request(pick_request(filling));
				// Mid-phase pause with the pipeline fully drained.
				if (n == ITEMS_PER_PHASE / 2)
					wait_for_drain();
			end
			wait_for_drain();
		end

		// All responses are in. Let a few cycles pass to catch stray words.
		repeat (8) @(posedge clk);
		if (table_shadow.failures == 0 && table_shadow.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_cell.sv
hw/rtl/ordered_key_value_table.sv
dv/testbench.sv
